>>> hdl/stma_pkg.sv
// Shared types, codes and helpers for the slot table allocator.
package stma_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned LEN_W  = 17;

   localparam logic [LEN_W-1:0]  LEN_MAX    = 17'h1FFFF;
   localparam logic [LEN_W-1:0]  ALIGN_MASK = ~17'd3;
   localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'hFFB00000;
   localparam logic [LEN_W-1:0]  RST_POOL_LENGTH = 17'd4096;

   localparam logic [1:0] REQ_ALLOC     = 2'd0;
   localparam logic [1:0] REQ_ALLOC_MAX = 2'd1;
   localparam logic [1:0] REQ_FREE      = 2'd2;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_FREE  = 2'd1,
      MARK_ALLOC = 2'd2
   } mark_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  len;
      mark_type          mark;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_NEXT,
      ST_PREV,
      ST_WRITE,
      ST_DONE
   } state_type;

   function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
   endfunction

endpackage

>>> hdl/slot_table_memory_allocator.sv
// Top level of the slot table allocator: register port, slot ring and sequencer.
//
// Request beats (req_valid/req_stall) carry an allocate, allocate-largest or
// free; each gives exactly one result beat (rsp_valid/rsp_stall) with the
// granted address, size and a fail status.
// The slot table is a ring of SLOTS cells that rotates one place a cycle
// while the sequencer scans; the sequencer sees each slot at the ring head.
// Every scan of the table is one full turn; a request makes these scans:
//   allocate / allocate-largest : find, rewrite
//   free                        : find, merge after, merge before, rewrite
//   zero-size alloc or bad type : no scan
// One request is in work at a time; the next may enter while the previous
// result waits in the output register, and the sequencer holds its own
// result while that register is still stalled. Reset, and any register
// write, rebuild the table at once: slot 0 free over the pool, all others
// empty. The user must write registers only when idle; it is not enforced.
module slot_table_memory_allocator #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_address,
   output logic [16:0] rsp_granted_size,
   output logic        rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] pool_base_ff, pool_base_in;
   logic [16:0] pool_len_ff, pool_len_in;
   logic        cfg_write;
   logic        init_load;
   logic        shift;
   stma_pkg::slot_type head, head_wr;
   stma_pkg::slot_type init0;
   stma_pkg::slot_type ring [SLOTS];

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      pool_base_in = pool_base_ff;
      pool_len_in  = pool_len_ff;
      if (reset) begin
         pool_base_in = stma_pkg::RST_POOL_BASE;
         pool_len_in  = stma_pkg::RST_POOL_LENGTH;
      end else if (cfg_write) begin
         if (paddr[2]) begin
            pool_len_in = pwdata[16:0];
         end else begin
            pool_base_in = pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pool_base_ff <= pool_base_in;
      pool_len_ff  <= pool_len_in;
   end

   assign prdata = paddr[2] ? {15'd0, pool_len_ff} : pool_base_ff;

   // rebuild the table from the values about to be stored
   assign init_load = reset || cfg_write;
   always_comb begin
      init0.base = pool_base_in;
      init0.len  = pool_len_in;
      init0.mark = stma_pkg::MARK_FREE;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_ring
      stma_pkg::slot_type init_v;
      stma_pkg::slot_type from_next;
      if (i == 0) begin : g_first
         assign init_v = init0;
      end else begin : g_rest
         assign init_v = '{base: '0, len: '0, mark: stma_pkg::MARK_EMPTY};
      end
      if (i == SLOTS - 1) begin : g_tail
         assign from_next = head_wr;
      end else begin : g_mid
         assign from_next = ring[i+1];
      end
      stma_cell u_cell (
         .clock      (clock),
         .init_load  (init_load),
         .init_value (init_v),
         .shift      (shift),
         .shift_in   (from_next),
         .slot_q     (ring[i])
      );
   end

   assign head = ring[0];

   stma_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_size           (req_size),
      .req_free_address   (req_free_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_address (rsp_result_address),
      .rsp_granted_size   (rsp_granted_size),
      .rsp_status         (rsp_status),
      .head               (head),
      .head_wr            (head_wr),
      .shift              (shift)
   );

endmodule

>>> hdl/stma_cell.sv
// One slot of the rotating slot ring.
module stma_cell (
   input  logic              clock,
   input  logic              init_load,
   input  stma_pkg::slot_type init_value,
   input  logic              shift,
   input  stma_pkg::slot_type shift_in,
   output stma_pkg::slot_type slot_q
);

   stma_pkg::slot_type slot_ff;
   stma_pkg::slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (init_load) begin
         slot_in = init_value;
      end else if (shift) begin
         slot_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_q = slot_ff;

endmodule

>>> hdl/stma_ctrl.sv
// Request sequencer: scans the slot ring head, rewrites slots and returns results.
module stma_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_size,
   input  logic [31:0]        req_free_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_result_address,
   output logic [16:0]        rsp_granted_size,
   output logic               rsp_status,
   input  stma_pkg::slot_type head,
   output stma_pkg::slot_type head_wr,
   output logic               shift
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   stma_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]  type_ff, type_in;
   logic [16:0] need_ff, need_in;
   logic [31:0] faddr_ff, faddr_in;
   logic        hit_ff, hit_in;
   logic        ok_ff, ok_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0] hit_base_ff, hit_base_in;
   logic [16:0] hit_len_ff, hit_len_in;
   logic        emp_ff, emp_in;
   logic [IDX_W-1:0] emp_idx_ff, emp_idx_in;
   logic        nxt_ff, nxt_in;
   logic [IDX_W-1:0] nxt_idx_ff, nxt_idx_in;
   logic [16:0] nxt_len_ff, nxt_len_in;
   logic [16:0] new_len_ff, new_len_in;
   logic        prv_ff, prv_in;
   logic [IDX_W-1:0] prv_idx_ff, prv_idx_in;
   logic        fail_ff, fail_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [16:0] rsp_size_ff, rsp_size_in;
   logic        rsp_status_ff, rsp_status_in;

   logic        accept;
   logic        last;
   logic [IDX_W-1:0] idx_next;
   logic        split;
   logic        out_free;
   logic [16:0] need_req;
   logic [31:0] hit_end;
   logic [16:0] len_eff;
   stma_pkg::mark_type mark_eff;
   logic [31:0] end_eff;

   assign accept   = req_valid && (state_ff == stma_pkg::ST_IDLE);
   assign last     = (idx_ff == LAST);
   // wrap at the last slot so every turn starts again at slot 0
   assign idx_next = last ? '0 : idx_ff + 1'b1;
   assign need_req = ({1'b0, req_size} + 17'd3) & stma_pkg::ALIGN_MASK;
   assign hit_end  = hit_base_ff + {15'd0, hit_len_ff};
   assign split    = emp_ff && (hit_len_ff > need_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // effective view of a slot after the forward merge
   always_comb begin
      mark_eff = head.mark;
      len_eff  = head.len;
      if (nxt_ff && idx_ff == nxt_idx_ff && nxt_idx_ff != hit_idx_ff) begin
         mark_eff = stma_pkg::MARK_EMPTY;
      end else if (idx_ff == hit_idx_ff) begin
         mark_eff = stma_pkg::MARK_FREE;
         len_eff  = new_len_ff;
      end
      end_eff = head.base + {15'd0, len_eff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stma_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_type == stma_pkg::REQ_ALLOC && req_size == 16'd0) ||
                   (req_type != stma_pkg::REQ_ALLOC && req_type != stma_pkg::REQ_ALLOC_MAX &&
                    req_type != stma_pkg::REQ_FREE)) begin
                  state_in = stma_pkg::ST_DONE;
               end else begin
                  state_in = stma_pkg::ST_FIND;
               end
            end
         end
         stma_pkg::ST_FIND: begin
            if (last) begin
               if (!hit_in || !ok_in) begin
                  state_in = stma_pkg::ST_DONE;
               end else if (type_ff == stma_pkg::REQ_FREE) begin
                  state_in = stma_pkg::ST_NEXT;
               end else begin
                  state_in = stma_pkg::ST_WRITE;
               end
            end
         end
         stma_pkg::ST_NEXT: if (last) state_in = stma_pkg::ST_PREV;
         stma_pkg::ST_PREV: if (last) state_in = stma_pkg::ST_WRITE;
         stma_pkg::ST_WRITE: if (last) state_in = stma_pkg::ST_DONE;
         stma_pkg::ST_DONE: if (out_free) state_in = stma_pkg::ST_IDLE;
         default: state_in = stma_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in      = idx_ff;
      type_in     = type_ff;
      need_in     = need_ff;
      faddr_in    = faddr_ff;
      hit_in      = hit_ff;
      ok_in       = ok_ff;
      hit_idx_in  = hit_idx_ff;
      hit_base_in = hit_base_ff;
      hit_len_in  = hit_len_ff;
      emp_in      = emp_ff;
      emp_idx_in  = emp_idx_ff;
      nxt_in      = nxt_ff;
      nxt_idx_in  = nxt_idx_ff;
      nxt_len_in  = nxt_len_ff;
      new_len_in  = new_len_ff;
      prv_in      = prv_ff;
      prv_idx_in  = prv_idx_ff;
      fail_in     = fail_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_wr     = head;
      shift       = 1'b0;

      unique case (state_ff)
         stma_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               type_in  = req_type;
               need_in  = need_req;
               faddr_in = req_free_address;
               hit_in   = 1'b0;
               ok_in    = 1'b1;
               emp_in   = 1'b0;
               nxt_in   = 1'b0;
               prv_in   = 1'b0;
               hit_len_in = '0;
               fail_in  = 1'b1;
            end
         end
         stma_pkg::ST_FIND: begin
            shift  = 1'b1;
            idx_in = idx_next;
            priority case (type_ff)
               stma_pkg::REQ_ALLOC: begin
                  if (!hit_ff && head.mark == stma_pkg::MARK_FREE && head.len >= need_ff) begin
                     hit_in = 1'b1;
                     hit_idx_in = idx_ff;
                     hit_base_in = head.base;
                     hit_len_in = head.len;
                  end
                  if (!emp_ff && head.mark == stma_pkg::MARK_EMPTY) begin
                     emp_in = 1'b1;
                     emp_idx_in = idx_ff;
                  end
               end
               stma_pkg::REQ_ALLOC_MAX: begin
                  if (head.mark == stma_pkg::MARK_FREE && head.len > hit_len_ff) begin
                     hit_in = 1'b1;
                     hit_idx_in = idx_ff;
                     hit_base_in = head.base;
                     hit_len_in = head.len;
                  end
               end
               default: begin
                  if (!hit_ff && head.base == faddr_ff) begin
                     hit_in = 1'b1;
                     ok_in = (head.mark == stma_pkg::MARK_ALLOC);
                     hit_idx_in = idx_ff;
                     hit_base_in = head.base;
                     hit_len_in = head.len;
                  end
               end
            endcase
         end
         stma_pkg::ST_NEXT: begin
            shift  = 1'b1;
            idx_in = idx_next;
            if (!nxt_ff && head.base == hit_end &&
                (idx_ff == hit_idx_ff || head.mark == stma_pkg::MARK_FREE)) begin
               nxt_in = 1'b1;
               nxt_idx_in = idx_ff;
               nxt_len_in = head.len;
            end
            if (last) begin
               new_len_in = nxt_in ? stma_pkg::sat_add(hit_len_ff, nxt_len_in) : hit_len_ff;
            end
         end
         stma_pkg::ST_PREV: begin
            shift  = 1'b1;
            idx_in = idx_next;
            if (!prv_ff && end_eff == hit_base_ff && mark_eff == stma_pkg::MARK_FREE) begin
               prv_in = 1'b1;
               prv_idx_in = idx_ff;
            end
         end
         stma_pkg::ST_WRITE: begin
            shift  = 1'b1;
            idx_in = idx_next;
            priority case (type_ff)
               stma_pkg::REQ_ALLOC: begin
                  if (idx_ff == hit_idx_ff) begin
                     head_wr.mark = stma_pkg::MARK_ALLOC;
                     if (split) head_wr.len = need_ff;
                  end else if (split && idx_ff == emp_idx_ff) begin
                     head_wr.mark = stma_pkg::MARK_FREE;
                     head_wr.base = hit_base_ff + {15'd0, need_ff};
                     head_wr.len  = hit_len_ff - need_ff;
                  end
               end
               stma_pkg::REQ_ALLOC_MAX: begin
                  if (idx_ff == hit_idx_ff) head_wr.mark = stma_pkg::MARK_ALLOC;
               end
               default: begin
                  if (idx_ff == hit_idx_ff) begin
                     head_wr.mark = prv_ff ? stma_pkg::MARK_EMPTY : stma_pkg::MARK_FREE;
                     head_wr.len  = (prv_ff && prv_idx_ff == hit_idx_ff) ?
                                    stma_pkg::sat_add(new_len_ff, new_len_ff) : new_len_ff;
                  end else if (nxt_ff && idx_ff == nxt_idx_ff) begin
                     head_wr.mark = stma_pkg::MARK_EMPTY;
                  end else if (prv_ff && idx_ff == prv_idx_ff) begin
                     head_wr.len = stma_pkg::sat_add(head.len, new_len_ff);
                  end
               end
            endcase
            if (last) fail_in = 1'b0;
         end
         stma_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fail_ff;
               if (fail_ff || type_ff == stma_pkg::REQ_FREE) begin
                  rsp_addr_in = '0;
                  rsp_size_in = '0;
               end else begin
                  rsp_addr_in = hit_base_ff;
                  rsp_size_in = (type_ff == stma_pkg::REQ_ALLOC) ? need_ff : hit_len_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stma_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      type_ff     <= type_in;
      need_ff     <= need_in;
      faddr_ff    <= faddr_in;
      hit_ff      <= hit_in;
      ok_ff       <= ok_in;
      hit_idx_ff  <= hit_idx_in;
      hit_base_ff <= hit_base_in;
      hit_len_ff  <= hit_len_in;
      emp_ff      <= emp_in;
      emp_idx_ff  <= emp_idx_in;
      nxt_ff      <= nxt_in;
      nxt_idx_ff  <= nxt_idx_in;
      nxt_len_ff  <= nxt_len_in;
      new_len_ff  <= new_len_in;
      prv_ff      <= prv_in;
      prv_idx_ff  <= prv_idx_in;
      fail_ff     <= fail_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall          = (state_ff != stma_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_granted_size   = rsp_size_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
